// ===== design/stc_pkg.sv =====
// Shared types and constants for the slope trigger window capture block.
// No dependencies; compiled first.
package stc_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int THRESH_W        = 16;
   localparam int RING_DEPTH_DEF  = 2048;
   localparam int HALF_WINDOW_DEF = 32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [THRESH_W-1:0]        thresh_type;

   localparam thresh_type THRESH_RESET = thresh_type'(500);

endpackage

// ===== design/stc_if.sv =====
// Valid/ready channel interfaces: sample input, window output, threshold write.
// Depends on stc_pkg.
interface stc_req_if;
   import stc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface stc_rsp_if;
   import stc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type window_sample;
   logic       window_last;
   modport source (output valid, output window_sample, output window_last, input ready);
   modport sink   (input valid, input window_sample, input window_last, output ready);
endinterface

interface stc_csr_if;
   import stc_pkg::*;
   logic       valid;
   logic       ready;
   thresh_type rise_threshold;
   modport source (output valid, output rise_threshold, input ready);
   modport sink   (input valid, input rise_threshold, output ready);
endinterface

// ===== design/slope_trigger_window_capture_top.sv =====
// Slope trigger window capture: pretrigger ring store with a read sequencer.
// Depends on stc_pkg and the channel interfaces in stc_if.sv.
//
// Channels: req_bus takes one signed 16-bit sample per word; rsp_bus returns
// the captured window, oldest first, window_last on the final word; csr_bus
// writes the rise threshold (always ready, write only while idle).
// Each sample is stored into the ring on its accept cycle. Samples that
// cause no window stream at one per cycle while no dump is in progress.
// A sample that completes a window starts a dump of 2*HALF_WINDOW words:
// after the accept the block enters ST_READ, then ST_SEND with the first
// word valid. Each word is one registered ring read in ST_READ followed by
// an output in ST_SEND, held while the receiver holds rsp_bus.ready low.
// req_bus.ready stays low during the dump; the single ring read port reads
// one word at a time. A stall just holds the current word on rsp_bus.
// Reset clears the indexes, armed flag and rise and loads threshold 500. The ring
// is not swept: a fill mark tracks written entries and unwritten entries
// read as zero, so the block is ready in the first cycle after reset.
module slope_trigger_window_capture_top #(
   parameter int RING_DEPTH  = stc_pkg::RING_DEPTH_DEF,
   parameter int HALF_WINDOW = stc_pkg::HALF_WINDOW_DEF
) (
   input  logic          clock,
   input  logic          reset,
   stc_req_if.sink       req_bus,
   stc_rsp_if.source     rsp_bus,
   stc_csr_if.sink       csr_bus
);
   import stc_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(2 * HALF_WINDOW);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(RING_DEPTH);
   localparam logic [AW:0]   HALF_X  = (AW+1)'(HALF_WINDOW);
   localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(2 * HALF_WINDOW - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   state_type       state_ff;
   logic [AW-1:0]   wr_ff;
   logic [AW-1:0]   trig_ff;
   logic [AW-1:0]   base_ff;
   logic            wrapped_ff;
   logic            armed_ff;
   logic [17:0]     rise_ff;
   sample_type      prev_ff;
   thresh_type      thresh_ff;
   logic [CW-1:0]   cnt_ff;
   logic            rd_ok_ff;
   sample_type      rd_data_ff;

   sample_type      ring [RING_DEPTH];

   logic            accept;
   logic            hit;
   logic [AW-1:0]   trig_in;
   logic            armed_in;
   logic [AW:0]     post_sum;
   logic [AW-1:0]   post_pos;
   logic            emit;
   logic [AW-1:0]   wr_in;
   logic [AW:0]     base_sum;
   logic [AW-1:0]   base_in;
   logic [AW:0]     rd_sum;
   logic [AW-1:0]   rd_addr;

   assign accept  = (state_ff == ST_IDLE) && req_bus.valid;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign hit      = $signed(rise_ff) > $signed({2'b00, thresh_ff});
   assign trig_in  = hit ? wr_ff : trig_ff;
   assign armed_in = hit || armed_ff;

   always_comb begin
      post_sum = {1'b0, trig_in} + HALF_X;
      if (post_sum >= DEPTH_X) begin
         post_sum = post_sum - DEPTH_X;
      end
      post_pos = post_sum[AW-1:0];

      base_sum = {1'b0, trig_in} + DEPTH_X - HALF_X;
      if (base_sum >= DEPTH_X) begin
         base_sum = base_sum - DEPTH_X;
      end
      base_in = base_sum[AW-1:0];

      rd_sum = {1'b0, base_ff} + (AW+1)'(cnt_ff);
      if (rd_sum >= DEPTH_X) begin
         rd_sum = rd_sum - DEPTH_X;
      end
      rd_addr = rd_sum[AW-1:0];
   end

   assign emit  = armed_in && (wr_ff == post_pos);
   assign wr_in = (wr_ff == LAST_POS) ? '0 : wr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (accept) begin
         ring[wr_in] <= req_bus.adc_sample;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wr_ff      <= '0;
         trig_ff    <= '0;
         base_ff    <= '0;
         wrapped_ff <= 1'b0;
         armed_ff   <= 1'b0;
         rise_ff    <= '0;
         prev_ff    <= '0;
         thresh_ff  <= THRESH_RESET;
         cnt_ff     <= '0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            thresh_ff <= csr_bus.rise_threshold;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  trig_ff    <= trig_in;
                  wr_ff      <= wr_in;
                  wrapped_ff <= wrapped_ff || (wr_ff == LAST_POS);
                  prev_ff    <= req_bus.adc_sample;
                  rise_ff    <= {{2{req_bus.adc_sample[15]}}, req_bus.adc_sample}
                                - {{2{prev_ff[15]}}, prev_ff};
                  if (emit) begin
                     armed_ff <= 1'b0;
                     base_ff  <= base_in;
                     cnt_ff   <= '0;
                     state_ff <= ST_READ;
                  end else begin
                     armed_ff <= armed_in;
                  end
               end
            end
            ST_READ: begin
               rd_ok_ff <= wrapped_ff || ((rd_addr != '0) && (rd_addr <= wr_ff));
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_bus.ready) begin
                  if (cnt_ff == LAST_CNT) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + CW'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid         = (state_ff == ST_SEND);
   assign rsp_bus.window_sample = rd_ok_ff ? rd_data_ff : '0;
   assign rsp_bus.window_last   = (cnt_ff == LAST_CNT);

endmodule
